// ----- sv/covariance_block_fold_assert.svh -----
// Assertion macros used by the checker of the covariance block fold.
`ifndef COVARIANCE_BLOCK_FOLD_ASSERT_SVH
`define COVARIANCE_BLOCK_FOLD_ASSERT_SVH

// Checked property that is switched off while reset is held.
`define CBF_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds through reset.
`define CBF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/cbf_pkg.sv -----
// Package with shared widths, codes and default sizes of the covariance block fold.
`default_nettype none

package cbf_pkg;

    // Field widths of the request and response channels.
    localparam int CMD_W = 2;
    localparam int ROW_W = 10;
    localparam int VAL_W = 32;
    localparam int SUM_W = 38;

    // Command codes carried by a request.
    localparam logic [CMD_W-1:0] CMD_ACC      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_CLR = 2'd2;

    // Default geometry of the full matrix.
    localparam int DEF_E_BINS     = 11;
    localparam int DEF_M_BINS     = 19;
    localparam int DEF_E_SPECTRA  = 7;
    localparam int DEF_M_SPECTRA  = 2;
    localparam int DEF_DETECTORS  = 3;
    localparam int DEF_POLARITIES = 2;
    localparam int DEF_CDIM =
        (DEF_E_BINS + DEF_M_BINS) * DEF_DETECTORS * DEF_POLARITIES;

    // Depth of the queue between front and back.
    localparam int QDEPTH = 4;

    // Fixed-point shift of the reciprocal multipliers used for constant division.
    localparam int RECIP_SH = 22;

    // Operation handed from front to back.
    typedef enum logic [1:0] {
        OP_ACC,
        OP_READ,
        OP_READ_CLR,
        OP_READ_ZERO
    } t_op;

endpackage

`default_nettype wire

// ----- sv/cbf_if.sv -----
// Request and response channel interfaces of the covariance block fold.
`default_nettype none

interface cbf_req_if import cbf_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        column;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output command, output row, output column,
                    output value, input ready);
    modport sink   (input valid, input command, input row, input column,
                    input value, output ready);
endinterface

interface cbf_rsp_if import cbf_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] sum;

    modport source (output valid, output sum, input ready);
    modport sink   (input valid, input sum, output ready);
endinterface

`default_nettype wire

// ----- sv/cbf_fifo.sv -----
// Short register queue between the front and back parts.
`default_nettype none

module cbf_fifo import cbf_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = QDEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_din,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_dout,
    output logic              o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & ~o_empty;
    assign o_dout  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_din;
        end
    end
endmodule

`default_nettype wire

// ----- sv/cbf_front.sv -----
// Front part: accepts requests, classifies them and folds full-matrix coordinates.
`default_nettype none

module cbf_front import cbf_pkg::*; #(
    parameter int E_BINS     = DEF_E_BINS,
    parameter int M_BINS     = DEF_M_BINS,
    parameter int E_SPECTRA  = DEF_E_SPECTRA,
    parameter int M_SPECTRA  = DEF_M_SPECTRA,
    parameter int DETECTORS  = DEF_DETECTORS,
    parameter int POLARITIES = DEF_POLARITIES,
    localparam int CDIM  = (E_BINS + M_BINS) * DETECTORS * POLARITIES,
    localparam int IDX_W = $clog2(CDIM * CDIM)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    cbf_req_if.sink                 i_req,
    input  wire logic               i_clearing,
    input  wire logic               i_full,
    output logic                    o_push,
    output t_op                     o_op,
    output logic [IDX_W-1:0]        o_idx,
    output logic signed [VAL_W-1:0] o_value
);
    localparam int EL_SPAN  = E_BINS * E_SPECTRA;
    localparam int DET_SPAN = EL_SPAN + M_BINS * M_SPECTRA;
    localparam int POL_SPAN = DET_SPAN * DETECTORS;
    localparam int FULL_DIM = POL_SPAN * POLARITIES;
    localparam int CDET     = E_BINS + M_BINS;
    localparam int CPOL     = CDET * DETECTORS;
    localparam int CW       = $clog2(CDIM);
    localparam int DW       = (DETECTORS > 1) ? $clog2(DETECTORS) : 1;
    localparam int PW       = ROW_W + RECIP_SH + 1;
    localparam int M_DET    = ((1 << RECIP_SH) + DET_SPAN - 1) / DET_SPAN;
    localparam int M_E      = ((1 << RECIP_SH) + E_BINS - 1) / E_BINS;
    localparam int M_M      = ((1 << RECIP_SH) + M_BINS - 1) / M_BINS;
    localparam int NST      = 6;

    // Control and value travel with every stage.
    logic                    r_v   [1:NST];
    t_op                     r_op  [1:NST];
    logic signed [VAL_W-1:0] r_val [1:NST];

    // Per-coordinate datapath, element 0 is the row and element 1 the column.
    logic [ROW_W-1:0] r_s1_x   [2];
    logic             r_s1_pol [2];
    logic [ROW_W-1:0] r_s1_r   [2];
    logic [ROW_W-1:0] r_s2_x   [2];
    logic             r_s2_pol [2];
    logic [ROW_W-1:0] r_s2_r   [2];
    logic [DW-1:0]    r_s2_det [2];
    logic [ROW_W-1:0] r_s3_x   [2];
    logic             r_s3_pol [2];
    logic [DW-1:0]    r_s3_det [2];
    logic [ROW_W-1:0] r_s3_qq  [2];
    logic             r_s3_mu  [2];
    logic [ROW_W-1:0] r_s4_x   [2];
    logic             r_s4_pol [2];
    logic [DW-1:0]    r_s4_det [2];
    logic [ROW_W-1:0] r_s4_qq  [2];
    logic             r_s4_mu  [2];
    logic [ROW_W-1:0] r_s4_quo [2];
    logic [CW-1:0]    r_s5_f   [2];
    logic [IDX_W-1:0] r_s6_idx;

    logic             en;
    logic             accept;
    logic             n_v1;
    t_op              n_op1;
    logic             in_full;
    logic             in_cdim;
    logic [ROW_W-1:0] in_x     [2];
    logic             n_pol    [2];
    logic [ROW_W-1:0] n_r      [2];
    logic [PW-1:0]    prod_det [2];
    logic [ROW_W-1:0] n_q      [2];
    logic             n_mu     [2];
    logic [ROW_W-1:0] n_qq     [2];
    logic [PW-1:0]    prod_quo [2];
    logic [CW-1:0]    n_f      [2];

    assign en          = ~i_full;
    assign i_req.ready = en & ~i_clearing;
    assign accept      = i_req.valid & i_req.ready;
    assign in_x[0]     = i_req.row;
    assign in_x[1]     = i_req.column;

    // Classify the request; dropped requests never enter the pipeline.
    always_comb begin
        in_full = (32'(i_req.row) < 32'(FULL_DIM)) && (32'(i_req.column) < 32'(FULL_DIM));
        in_cdim = (32'(i_req.row) < 32'(CDIM)) && (32'(i_req.column) < 32'(CDIM));
        n_v1    = 1'b0;
        n_op1   = OP_ACC;
        unique case (i_req.command)
            CMD_ACC: begin
                n_v1  = in_full;
                n_op1 = OP_ACC;
            end
            CMD_READ: begin
                n_v1  = 1'b1;
                n_op1 = in_cdim ? OP_READ : OP_READ_ZERO;
            end
            CMD_READ_CLR: begin
                n_v1  = 1'b1;
                n_op1 = in_cdim ? OP_READ_CLR : OP_READ_ZERO;
            end
            default: begin
                n_v1  = 1'b0;
                n_op1 = OP_ACC;
            end
        endcase
    end

    // Folding arithmetic, one step per stage.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_pol[k]    = (32'(in_x[k]) >= 32'(POL_SPAN));
            n_r[k]      = ROW_W'(32'(in_x[k]) - (n_pol[k] ? 32'(POL_SPAN) : 32'd0));
            prod_det[k] = PW'(r_s1_r[k]) * PW'(M_DET);
            n_q[k]      = ROW_W'(32'(r_s2_r[k]) - 32'(r_s2_det[k]) * 32'(DET_SPAN));
            n_mu[k]     = (32'(n_q[k]) >= 32'(EL_SPAN));
            n_qq[k]     = n_mu[k] ? ROW_W'(32'(n_q[k]) - 32'(EL_SPAN)) : n_q[k];
            prod_quo[k] = PW'(r_s3_qq[k]) * PW'(r_s3_mu[k] ? M_M : M_E);
            if (r_op[4] == OP_ACC) begin
                n_f[k] = CW'(32'(r_s4_pol[k]) * 32'(CPOL)
                           + 32'(r_s4_det[k]) * 32'(CDET)
                           + (r_s4_mu[k] ? 32'(E_BINS) : 32'd0)
                           + 32'(r_s4_qq[k])
                           - 32'(r_s4_quo[k]) * (r_s4_mu[k] ? 32'(M_BINS) : 32'(E_BINS)));
            end else begin
                n_f[k] = CW'(r_s4_x[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 1; n <= NST; n++) begin
                r_v[n] <= 1'b0;
            end
        end else if (en) begin
            r_v[1] <= accept & n_v1;
            for (int n = 2; n <= NST; n++) begin
                r_v[n] <= r_v[n-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op[1]  <= n_op1;
            r_val[1] <= i_req.value;
            for (int n = 2; n <= NST; n++) begin
                r_op[n]  <= r_op[n-1];
                r_val[n] <= r_val[n-1];
            end
            for (int k = 0; k < 2; k++) begin
                r_s1_x[k]   <= in_x[k];
                r_s1_pol[k] <= n_pol[k];
                r_s1_r[k]   <= n_r[k];
                r_s2_x[k]   <= r_s1_x[k];
                r_s2_pol[k] <= r_s1_pol[k];
                r_s2_r[k]   <= r_s1_r[k];
                r_s2_det[k] <= prod_det[k][RECIP_SH +: DW];
                r_s3_x[k]   <= r_s2_x[k];
                r_s3_pol[k] <= r_s2_pol[k];
                r_s3_det[k] <= r_s2_det[k];
                r_s3_qq[k]  <= n_qq[k];
                r_s3_mu[k]  <= n_mu[k];
                r_s4_x[k]   <= r_s3_x[k];
                r_s4_pol[k] <= r_s3_pol[k];
                r_s4_det[k] <= r_s3_det[k];
                r_s4_qq[k]  <= r_s3_qq[k];
                r_s4_mu[k]  <= r_s3_mu[k];
                r_s4_quo[k] <= prod_quo[k][RECIP_SH +: ROW_W];
                r_s5_f[k]   <= n_f[k];
            end
            r_s6_idx <= IDX_W'(32'(r_s5_f[0]) * 32'(CDIM) + 32'(r_s5_f[1]));
        end
    end

    assign o_push  = r_v[NST] & en;
    assign o_op    = r_op[NST];
    assign o_idx   = r_s6_idx;
    assign o_value = r_val[NST];
endmodule

`default_nettype wire

// ----- sv/cbf_back.sv -----
// Back part: contracted-matrix store with read-modify-write, clearing pass and output register.
`default_nettype none

module cbf_back import cbf_pkg::*; #(
    parameter int CDIM = DEF_CDIM,
    localparam int DEPTH = CDIM * CDIM,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_empty,
    input  wire t_op                     i_op,
    input  wire logic [IDX_W-1:0]        i_idx,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic                         o_pop,
    output logic                         o_clearing,
    cbf_rsp_if.source                    o_rsp
);
    logic [SUM_W-1:0]        r_mem [DEPTH];
    logic [SUM_W-1:0]        r_rdata;
    logic                    r_clearing;
    logic [IDX_W-1:0]        r_clr_addr;
    logic                    r_s2_v;
    t_op                     r_s2_op;
    logic [IDX_W-1:0]        r_s2_idx;
    logic signed [VAL_W-1:0] r_s2_val;
    logic                    r_fwd_v;
    logic [IDX_W-1:0]        r_fwd_addr;
    logic [SUM_W-1:0]        r_fwd_data;
    logic                    r_out_v;
    logic [SUM_W-1:0]        r_out_sum;

    logic                    back_en;
    logic [SUM_W-1:0]        cur;
    logic [SUM_W-1:0]        ext_val;
    logic                    s2_we;
    logic [SUM_W-1:0]        s2_wdata;
    logic                    s2_rsp;
    logic [SUM_W-1:0]        s2_sum;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [SUM_W-1:0]        mem_wdata;

    assign back_en    = ~r_out_v | o_rsp.ready;
    assign o_pop      = back_en & ~i_empty & ~r_clearing;
    assign o_clearing = r_clearing;

    // The write of the previous step is not yet in the read data; take it instead.
    assign cur     = (r_fwd_v && (r_fwd_addr == r_s2_idx)) ? r_fwd_data : r_rdata;
    assign ext_val = {{(SUM_W - VAL_W){r_s2_val[VAL_W-1]}}, r_s2_val};

    always_comb begin
        s2_we    = 1'b0;
        s2_wdata = cur;
        s2_rsp   = 1'b0;
        s2_sum   = cur;
        unique case (r_s2_op)
            OP_ACC: begin
                s2_we    = 1'b1;
                s2_wdata = cur + ext_val;
            end
            OP_READ: begin
                s2_rsp = 1'b1;
            end
            OP_READ_CLR: begin
                s2_rsp   = 1'b1;
                s2_we    = 1'b1;
                s2_wdata = '0;
            end
            OP_READ_ZERO: begin
                s2_rsp = 1'b1;
                s2_sum = '0;
            end
        endcase
    end

    assign mem_we    = r_clearing | (back_en & r_s2_v & s2_we);
    assign mem_waddr = r_clearing ? r_clr_addr : r_s2_idx;
    assign mem_wdata = r_clearing ? '0 : s2_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (o_pop) begin
            r_rdata <= r_mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s2_v     <= 1'b0;
            r_fwd_v    <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == IDX_W'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (back_en) begin
                r_s2_v  <= o_pop;
                r_fwd_v <= r_s2_v & s2_we;
                r_out_v <= r_s2_v & s2_rsp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (back_en) begin
            r_s2_op    <= i_op;
            r_s2_idx   <= i_idx;
            r_s2_val   <= i_value;
            r_fwd_addr <= r_s2_idx;
            r_fwd_data <= s2_wdata;
            r_out_sum  <= s2_sum;
        end
    end

    assign o_rsp.valid = r_out_v;
    assign o_rsp.sum   = r_out_sum;
endmodule

`default_nettype wire

// ----- sv/covariance_block_fold.sv -----
// Top level of the covariance block fold: front, queue and back.
//
// The block folds a full covariance matrix into a contracted one held in an
// internal store. Requests arrive on i_req with a command, a row, a column and
// a signed Q4.28 value. An accumulate request adds its value into the
// contracted entry that its row and column fold to; a read request returns the
// contracted entry on o_rsp, and a read-and-clear request also zeroes it.
// Accumulate requests produce no response; reads outside the contracted
// matrix return zero. One request can be accepted per cycle while i_req.ready
// is high. A read passes through six front stages that fold the coordinates,
// then through the queue, and in the back through the store read and the
// output register. The store has a read port and a write port; the back does
// one read-modify-write per cycle while the output register can advance, with
// forwarding of the previous write.
// After reset the store is swept to zero one entry per cycle, all CDIM * CDIM
// entries (32400 with the default geometry), and i_req.ready stays low until
// the sweep ends. When the receiver holds o_rsp.ready low, the response waits
// in the output register, the back stops, the queue fills and i_req.ready
// then drops until the response is taken.
`default_nettype none

module covariance_block_fold import cbf_pkg::*; #(
    parameter int E_BINS     = DEF_E_BINS,
    parameter int M_BINS     = DEF_M_BINS,
    parameter int E_SPECTRA  = DEF_E_SPECTRA,
    parameter int M_SPECTRA  = DEF_M_SPECTRA,
    parameter int DETECTORS  = DEF_DETECTORS,
    parameter int POLARITIES = DEF_POLARITIES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cbf_req_if.sink   i_req,
    cbf_rsp_if.source o_rsp
);
    // Contracted dimension and the width of a flat store address.
    localparam int CDIM  = (E_BINS + M_BINS) * DETECTORS * POLARITIES;
    localparam int IDX_W = $clog2(CDIM * CDIM);
    localparam int OP_W  = $bits(t_op);
    localparam int QW    = OP_W + IDX_W + VAL_W;

    logic                    front_push;
    t_op                     front_op;
    logic [IDX_W-1:0]        front_idx;
    logic signed [VAL_W-1:0] front_value;
    logic                    q_full;
    logic                    q_empty;
    logic                    q_pop;
    logic [QW-1:0]           q_dout;
    logic                    clearing;
    t_op                     head_op;
    logic [IDX_W-1:0]        head_idx;
    logic signed [VAL_W-1:0] head_value;

    // The front classifies each request and turns its coordinates into a
    // flat address of the contracted store.
    cbf_front #(
        .E_BINS     (E_BINS),
        .M_BINS     (M_BINS),
        .E_SPECTRA  (E_SPECTRA),
        .M_SPECTRA  (M_SPECTRA),
        .DETECTORS  (DETECTORS),
        .POLARITIES (POLARITIES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_clearing (clearing),
        .i_full     (q_full),
        .o_push     (front_push),
        .o_op       (front_op),
        .o_idx      (front_idx),
        .o_value    (front_value)
    );

    // The queue lets the front keep folding while the back waits on the receiver.
    cbf_fifo #(
        .W     (QW),
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_din   ({front_op, front_idx, front_value}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_dout  (q_dout),
        .o_empty (q_empty)
    );

    assign head_op    = t_op'(q_dout[QW-1 -: OP_W]);
    assign head_idx   = q_dout[VAL_W +: IDX_W];
    assign head_value = q_dout[VAL_W-1:0];

    // The back owns the store, its clearing sweep and the response register.
    cbf_back #(
        .CDIM (CDIM)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_op       (head_op),
        .i_idx      (head_idx),
        .i_value    (head_value),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_rsp      (o_rsp)
    );
endmodule

`default_nettype wire

// ----- sv/cbf_checker.sv -----
// Port-level checker of the covariance block fold and its bind to the top level.
`default_nettype none

`include "covariance_block_fold_assert.svh"

module cbf_checker import cbf_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_req_valid,
    input wire logic             i_req_ready,
    input wire logic [CMD_W-1:0] i_req_command,
    input wire logic             i_rsp_valid,
    input wire logic             i_rsp_ready,
    input wire logic [SUM_W-1:0] i_rsp_sum
);
    // Reads accepted whose response has not yet been taken.
    logic [7:0] r_pending;
    logic       read_acc;
    logic       rsp_acc;

    assign read_acc = i_req_valid & i_req_ready
                    & ((i_req_command == CMD_READ) || (i_req_command == CMD_READ_CLR));
    assign rsp_acc  = i_rsp_valid & i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            unique case ({read_acc, rsp_acc})
                2'b10:   r_pending <= r_pending + 1'b1;
                2'b01:   r_pending <= r_pending - 1'b1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    // The store sweep holds off requests in the cycle after reset.
    `CBF_ASSERT_ALWAYS(a_ready_low_after_reset, i_clk, !i_rst_n |=> !i_req_ready,
        "request accepted right after reset")

    // Reset empties the output register.
    `CBF_ASSERT_ALWAYS(a_no_rsp_after_reset, i_clk, !i_rst_n |=> !i_rsp_valid,
        "response valid right after reset")

    // Every response answers an earlier read.
    `CBF_ASSERT_RST(a_rsp_has_read, i_clk, i_rst_n, i_rsp_valid |-> (r_pending != '0),
        "response without an outstanding read")

    // A stalled response keeps its value.
    `CBF_ASSERT_RST(a_rsp_hold, i_clk, i_rst_n,
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_sum)),
        "stalled response changed")
endmodule

bind covariance_block_fold cbf_checker u_cbf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_command (i_req.command),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_sum     (o_rsp.sum)
);

`default_nettype wire
